// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at each rising clock edge while reset is low.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property at each rising clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/kms_pkg.sv =====
// Package with types, constants and the base decoder of the k-mer minimizer stream.
package kms_pkg;

  localparam logic [5:0] KMER_LENGTH_RESET = 6'd16;

  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_UPPER_C = 7'h43;
  localparam logic [6:0] CH_UPPER_G = 7'h47;
  localparam logic [6:0] CH_UPPER_T = 7'h54;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_LOWER_C = 7'h63;
  localparam logic [6:0] CH_LOWER_G = 7'h67;
  localparam logic [6:0] CH_LOWER_T = 7'h74;

  localparam logic [1:0] BASE_A = 2'h0;
  localparam logic [1:0] BASE_C = 2'h1;
  localparam logic [1:0] BASE_G = 2'h2;
  localparam logic [1:0] BASE_T = 2'h3;

  typedef struct packed {
    logic [6:0] base_char;
    logic       segment_end;
  } kms_item_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } kms_base_t;

  function automatic kms_base_t decode_base(input logic [6:0] ch);
    kms_base_t r;
    r.ok = 1'b1;
    r.code = BASE_A;
    case (ch)
      CH_UPPER_A, CH_LOWER_A: r.code = BASE_A;
      CH_UPPER_C, CH_LOWER_C: r.code = BASE_C;
      CH_UPPER_G, CH_LOWER_G: r.code = BASE_G;
      CH_UPPER_T, CH_LOWER_T: r.code = BASE_T;
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/kmer_minimizer_stream_top.sv =====
// The input register holds each base, and the output register loads the segment result
// when the last base is taken from it, so m_axis_tvalid rises as that base leaves.
// Throughput: one base per cycle; while a result waits on m_axis, bases still flow until
// the next last base reaches the input register, which then holds s_axis_tready low.
// Reset: rst is synchronous; it sets kmer_length to 16, clears the window and the
// segment minimum, empties both registers, and sets the invalid tag to all ones.
module kmer_minimizer_stream_top
  import kms_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [5:0]              cfg_data,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // Bits from the lowest: base_char[6:0], one zero pad bit.
  input  logic [7:0]              s_axis_tdata,
  input  logic                    s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // Bits from the lowest: min_kmer[WORD_BITS-1:0], kmer_found, zero pad to a byte.
  output logic [((WORD_BITS+8)/8)*8-1:0] m_axis_tdata
);

  localparam int OUT_BITS = ((WORD_BITS + 8) / 8) * 8;
  localparam int PAD_BITS = OUT_BITS - WORD_BITS - 1;

  logic                 [5:0] kmer_length;
  kms_item_t            in_item;
  kms_item_t            cur_item;
  logic                 cur_valid;
  logic                 take;
  logic                 out_free;
  logic [WORD_BITS-1:0] res_min;
  logic                 res_found;
  logic [OUT_BITS-1:0]  res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KMER_LENGTH_RESET;
    end else if (cfg_we) begin
      kmer_length <= cfg_data;
    end
  end

  assign in_item.base_char = s_axis_tdata[6:0];
  assign in_item.segment_end = s_axis_tlast;

  assign take = cur_valid && (!cur_item.segment_end || out_free);

  kms_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .take     (take),
    .valid    (cur_valid),
    .item     (cur_item)
  );

  kms_core #(
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (take),
    .item        (cur_item),
    .kmer_length (kmer_length),
    .res_min     (res_min),
    .res_found   (res_found)
  );

  assign res_data = {{PAD_BITS{1'b0}}, res_found, res_min};

  kms_out_reg #(
    .DATA_BITS (OUT_BITS)
  ) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && cur_item.segment_end),
    .load_data (res_data),
    .free      (out_free),
    .valid     (m_axis_tvalid),
    .ready     (m_axis_tready),
    .data      (m_axis_tdata)
  );

endmodule

// ===== hdl/kms_in_reg.sv =====
// Input register stage holding one accepted base request.
module kms_in_reg
  import kms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  kms_item_t in_item,
  input  logic      take,
  output logic      valid,
  output kms_item_t item
);

  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== hdl/kms_core.sv =====
// Window, run counter, segment minimum and invalid tag update for one base per cycle while step is high.
module kms_core
  import kms_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  kms_item_t            item,
  input  logic [5:0]           kmer_length,
  output logic [WORD_BITS-1:0] res_min,
  output logic                 res_found
);

  localparam logic [5:0] KMAX = 6'(WORD_BITS / 2);

  logic [WORD_BITS-1:0] window_bits;
  logic [5:0]           valid_run;
  logic [WORD_BITS-1:0] best_kmer;
  logic                 best_seen;
  logic [WORD_BITS-1:0] invalid_tag;

  logic [WORD_BITS-1:0] window_bits_next;
  logic [5:0]           valid_run_next;
  logic [WORD_BITS-1:0] best_kmer_next;
  logic                 best_seen_next;

  logic [5:0]           k_eff;
  logic [6:0]           mask_bits;
  logic [WORD_BITS-1:0] kmask;
  kms_base_t            base;

  always_comb begin
    k_eff = kmer_length;
    if (k_eff == 6'd0) begin
      k_eff = 6'd1;
    end
    if (k_eff > KMAX) begin
      k_eff = KMAX;
    end
    mask_bits = {k_eff, 1'b0};
    for (int i = 0; i < WORD_BITS; i++) begin
      kmask[i] = (7'(i) < mask_bits);
    end
  end

  always_comb begin
    base = decode_base(item.base_char);
    window_bits_next = '0;
    valid_run_next = '0;
    best_kmer_next = best_kmer;
    best_seen_next = best_seen;
    if (base.ok) begin
      window_bits_next = {window_bits[WORD_BITS-3:0], base.code} & kmask;
      valid_run_next = (valid_run >= k_eff) ? k_eff : valid_run + 6'd1;
      if (valid_run_next >= k_eff) begin
        if (!best_seen || window_bits_next < best_kmer) begin
          best_kmer_next = window_bits_next;
        end
        best_seen_next = 1'b1;
      end
    end
    res_found = best_seen_next;
    res_min = best_seen_next ? best_kmer_next : invalid_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
      valid_run <= '0;
      best_kmer <= '1;
      best_seen <= 1'b0;
      invalid_tag <= '1;
    end else if (step) begin
      if (item.segment_end) begin
        window_bits <= '0;
        valid_run <= '0;
        best_kmer <= '1;
        best_seen <= 1'b0;
        if (!best_seen_next) begin
          invalid_tag <= invalid_tag - WORD_BITS'(1);
        end
      end else begin
        window_bits <= window_bits_next;
        valid_run <= valid_run_next;
        best_kmer <= best_kmer_next;
        best_seen <= best_seen_next;
      end
    end
  end

endmodule

// ===== hdl/kms_out_reg.sv =====
// Output register holding one segment result until the downstream side takes it.
module kms_out_reg #(
  parameter int DATA_BITS = 72
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [DATA_BITS-1:0] load_data,
  output logic                 free,
  output logic                 valid,
  input  logic                 ready,
  output logic [DATA_BITS-1:0] data
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= load_data;
    end
  end

endmodule

// ===== hdl/kms_checker.sv =====
// Port checker for the k-mer minimizer stream and its bind to the top level.
`include "assert_macros.svh"

module kms_checker #(
  parameter int WORD_BITS = 64
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((WORD_BITS+8)/8)*8-1:0]    m_axis_tdata
);

  // A result stalled by the downstream side stays in place.
  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or vanished")

  // Reset empties the output register.
  `ASSERT_ALWAYS(a_out_reset, clk, rst |=> !m_axis_tvalid, "result valid right after reset")

  // A fresh result follows a last base that was accepted and then taken from the input register.
  `ASSERT_CLK(a_out_cause, clk, rst, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2), "result without a segment end")

endmodule

bind kmer_minimizer_stream_top kms_checker #(.WORD_BITS(WORD_BITS)) u_kms_checker (.*);

// ===== verif/kmer_minimizer_stream_top_test.sv =====
// Self-checking testbench for the k-mer minimizer stream with a scoreboard predictor.
`timescale 1ns / 1ps

module kmer_minimizer_stream_top_test;
  import kms_pkg::*;

  localparam int WORD_BITS = 64;
  localparam int KMAX = WORD_BITS / 2;
  localparam int OUT_W = ((WORD_BITS + 8) / 8) * 8;
  localparam int TARGET_BASES = 1750;
  localparam logic [6:0] CH_NUL = 7'h00;
  localparam logic [6:0] CH_DEL = 7'h7F;
  localparam logic [6:0] CH_UPPER_N = 7'h4E;

  class minimizer_scoreboard;
    logic [5:0] kmer_len;
    logic [WORD_BITS-1:0] window;
    int unsigned run;
    logic [WORD_BITS-1:0] best;
    bit best_seen;
    logic [WORD_BITS-1:0] inv_tag;
    logic [WORD_BITS:0] pending_minima[$];
    int errors;
    int matched;

    function void clear_segment();
      window = '0;
      run = 0;
      best = '1;
      best_seen = 1'b0;
    endfunction

    function void reset();
      kmer_len = KMER_LENGTH_RESET;
      clear_segment();
      inv_tag = '1;
      pending_minima.delete();
    endfunction

    function void set_length(logic [5:0] v);
      kmer_len = v;
    endfunction

    function int unsigned eff_k();
      int unsigned k;
      k = kmer_len;
      if (k == 0) k = 1;
      if (k > KMAX) k = KMAX;
      return k;
    endfunction

    function void accept_base(logic [6:0] ch, logic last);
      int unsigned k;
      logic [WORD_BITS-1:0] kmask;
      logic [1:0] code;
      bit ok;
      k = eff_k();
      kmask = (2 * k >= WORD_BITS) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
      ok = 1'b1;
      code = BASE_A;
      case (ch)
        CH_UPPER_A, CH_LOWER_A: code = BASE_A;
        CH_UPPER_C, CH_LOWER_C: code = BASE_C;
        CH_UPPER_G, CH_LOWER_G: code = BASE_G;
        CH_UPPER_T, CH_LOWER_T: code = BASE_T;
        default: ok = 1'b0;
      endcase
      if (ok) begin
        window = ((window << 2) | code) & kmask;
        run = (run >= k) ? k : run + 1;
        if (run >= k) begin
          if (!best_seen || window < best) best = window;
          best_seen = 1'b1;
        end
      end else begin
        window = '0;
        run = 0;
      end
      if (last) begin
        if (best_seen) begin
          pending_minima.insert(pending_minima.size(), {1'b1, best});
        end else begin
          pending_minima.insert(pending_minima.size(), {1'b0, inv_tag});
          inv_tag = inv_tag - 1'b1;
        end
        clear_segment();
      end
    endfunction

    task note_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_segment_result(logic [OUT_W-1:0] data);
      logic [WORD_BITS:0] want;
      if (pending_minima.size() == 0) begin
        note_mismatch($sformatf("result %h with no request pending", data));
      end else begin
        want = pending_minima.pop_front();
        if (data[WORD_BITS-1:0] !== want[WORD_BITS-1:0])
          note_mismatch($sformatf("min_kmer %h, expected %h",
                                  data[WORD_BITS-1:0], want[WORD_BITS-1:0]));
        if (data[WORD_BITS] !== want[WORD_BITS])
          note_mismatch($sformatf("kmer_found %b, expected %b",
                                  data[WORD_BITS], want[WORD_BITS]));
        matched++;
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  minimizer_scoreboard sb;
  int idle_pct = 8;
  int stall_pct = 8;
  int bases_sent = 0;
  int settings_used = 0;

  kmer_minimizer_stream_top #(
    .WORD_BITS(WORD_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_segment_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_base(input logic [6:0] ch, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, ch};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.accept_base(ch, last);
    bases_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_minima.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [5:0] len);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_length(len);
    settings_used++;
  endtask

  function automatic logic [6:0] random_base();
    case ($urandom_range(0, 7))
      0: return CH_UPPER_A;
      1: return CH_UPPER_C;
      2: return CH_UPPER_G;
      3: return CH_UPPER_T;
      4: return CH_LOWER_A;
      5: return CH_LOWER_C;
      6: return CH_LOWER_G;
      default: return CH_LOWER_T;
    endcase
  endfunction

  function automatic logic [6:0] random_t();
    return $urandom_range(0, 1) ? CH_UPPER_T : CH_LOWER_T;
  endfunction

  initial begin
    int lengths[12] = '{16, 1, 63, 2, 32, 0, 5, 33, 12, 31, 3, 8};
    logic [6:0] seg_chars[$];
    int phase;
    int budget;
    int kind;
    int k;
    int n;
    bit split;
    logic [6:0] fill;

    sb = new();
    sb.reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two segments with no full k-mer report the running invalid tag.
    send_base(CH_NUL, 1'b1);
    send_base(CH_DEL, 1'b1);
    write_length(6'd1);
    send_base(CH_UPPER_A, 1'b0);
    send_base(CH_UPPER_C, 1'b0);
    send_base(CH_UPPER_G, 1'b0);
    send_base(CH_UPPER_T, 1'b0);
    send_base(CH_LOWER_A, 1'b0);
    send_base(CH_LOWER_C, 1'b0);
    send_base(CH_LOWER_G, 1'b0);
    send_base(CH_LOWER_T, 1'b1);
    // The last base of a segment still forms a k-mer.
    send_base(CH_UPPER_N, 1'b0);
    send_base(CH_UPPER_T, 1'b1);
    // The length changes while a segment is open.
    send_base(CH_UPPER_G, 1'b0);
    send_base(CH_UPPER_C, 1'b0);
    write_length(6'd2);
    send_base(CH_LOWER_A, 1'b1);
    // A length of zero behaves as one.
    write_length(6'd0);
    send_base(CH_LOWER_C, 1'b0);
    send_base(CH_UPPER_A, 1'b1);

    phase = 0;
    while (bases_sent < TARGET_BASES) begin
      write_length(phase < 12 ? lengths[phase][5:0] : 6'($urandom_range(0, 63)));
      idle_pct = (phase == 2) ? 0 : 8;
      stall_pct = (phase == 2) ? 0 : 8;
      split = (phase % 3 == 1);
      k = sb.eff_k();
      if (k == KMAX) begin
        // An all-T k-mer at full width equals the cleared minimum value.
        for (int i = 0; i < k; i++) send_base(random_t(), i == k - 1);
      end
      budget = $urandom_range(90, 200);
      while (budget > 0) begin
        seg_chars.delete();
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          n = $urandom_range(1, 2 * k + 8);
          for (int i = 0; i < n; i++)
            seg_chars.insert(seg_chars.size(), ($urandom_range(0, 99) < 4) ?
                             7'($urandom_range(0, 127)) : random_base());
        end else if (kind < 80) begin
          n = $urandom_range(k, k + 3);
          for (int i = 0; i < n; i++)
            seg_chars.insert(seg_chars.size(), ($urandom_range(0, 99) < 30) ?
                             ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) :
                             random_t());
        end else if (kind < 90) begin
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++)
            seg_chars.insert(seg_chars.size(), 7'($urandom_range(0, 127)));
        end else begin
          fill = $urandom_range(0, 1) ? CH_UPPER_N : CH_NUL;
          for (int i = 0; i < k - 1; i++) seg_chars.insert(seg_chars.size(), random_base());
          seg_chars.insert(seg_chars.size(), fill);
          for (int i = 0; i < k - 1; i++) seg_chars.insert(seg_chars.size(), random_base());
        end
        foreach (seg_chars[i]) begin
          send_base(seg_chars[i], i == seg_chars.size() - 1);
          budget--;
          if (split && budget == 0) break;
        end
      end
      phase++;
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d bases over %0d length settings, including reserved and non-base codes.",
             bases_sent, settings_used);
    $display("Checked %0d segment results; %0d mismatches.", sb.matched, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
